/* rtl/sha256_pkg.sv */
// Package: SHA-256 constants, controller types and round functions.
`default_nettype none
package sha256_pkg;

    localparam int unsigned LenPos = 56;
    localparam logic [7:0] PadMark = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH,
        ST_PAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       load_byte;
        logic       start_block;
        logic       pad_write;
        logic       finish;
        logic       reinit;
    } t_cmd;

    typedef struct packed {
        logic       block_full;
        logic       round_done;
        logic       len_done;
    } t_status;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[idx];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

/* rtl/sha256_message_hasher_unit.sv */
// Top level: SHA-256 hasher over a byte stream, digest as eight words.
// Input bytes are taken while idle; a full block holds input until its rounds finish.
// End of message: pad one byte per cycle to the block end,
// one or two blocks; the digest words follow the last padding block.
// The shared round unit does one round per cycle and sets the block time.
// Synchronous active-low reset loads the initial hash and clears counts.
`default_nettype none
module sha256_message_hasher_unit
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], has_byte[8], zeros
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // digest_word[31:0], word_index[34:32], zeros
    output logic             m_axis_tlast
);

    t_cmd       cmd;
    t_status    status;
    logic [2:0] idx;
    logic [31:0] digest;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_has_byte   (s_axis_tdata[8]),
        .i_is_last    (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_word_index (idx)
    );

    sha256_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_byte       (s_axis_tdata[7:0]),
        .i_word_index (idx),
        .o_status     (status),
        .o_digest     (digest)
    );

    assign m_axis_tdata = {5'd0, idx, digest};
    assign m_axis_tlast = (idx == 3'd7);

endmodule
`default_nettype wire

/* rtl/sha256_ctrl.sv */
// Controller: sequences byte loading, rounds, padding and digest output.
`default_nettype none
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_has_byte,
    input  wire logic    i_is_last,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output logic [2:0]   o_word_index
);

    t_state     r_state, n_state;
    logic       r_last, n_last;
    logic [2:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = i_has_byte;
                    n_last = i_is_last;
                    if (i_has_byte && i_status.block_full) begin
                        o_cmd.start_block = 1'b1;
                        n_state = ST_ROUND;
                    end else if (i_is_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (i_status.round_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (i_status.len_done) begin
                    n_state = ST_EMIT;
                    n_idx = '0;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_cmd.pad_write = 1'b1;
                if (i_status.block_full) begin
                    o_cmd.start_block = 1'b1;
                    n_state = ST_ROUND;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.reinit = 1'b1;
                        n_last = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_word_index = r_idx;

endmodule
`default_nettype wire

/* rtl/sha256_dpath.sv */
// Datapath: block shift register, message schedule, round unit and chaining words.
`default_nettype none
module sha256_dpath
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [7:0]  i_byte,
    input  wire logic [2:0]  i_word_index,
    output t_status          o_status,
    output logic [31:0]      o_digest
);

    logic [5:0]  r_fill;
    logic [63:0] r_len;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_marked;
    logic        r_len_ok;
    logic        r_len_done;

    logic [31:0] w_cur, s0, s1, w_next, t1, t2, e, a;
    logic [63:0] bits;
    logic [7:0]  shift_byte;
    logic        shift_en;

    sha256_msg_load u_load (
        .i_byte   (i_byte),
        .i_pad    (i_cmd.pad_write),
        .i_marked (r_marked),
        .i_len_ok (r_len_ok),
        .i_fill   (r_fill),
        .i_bits   (bits),
        .o_byte   (shift_byte)
    );

    assign shift_en = i_cmd.load_byte || i_cmd.pad_write;
    assign bits = r_len << 3;
    assign w_cur = r_w[0];
    assign s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_next = r_w[0] + s0 + r_w[9] + s1;
    assign e = r_v[4];
    assign a = r_v[0];
    assign t1 = r_v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_const(r_rnd) + w_cur;
    assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign o_status.block_full = (r_fill == 6'd63);
    assign o_status.round_done = r_busy && (r_rnd == 6'd63);
    assign o_status.len_done   = r_len_done;
    assign o_digest = r_h[i_word_index];

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            r_w[15] <= {r_w[15][23:0], shift_byte};
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_next;
        end
        if (i_cmd.start_block) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len <= '0;
            r_busy <= 1'b0;
            r_rnd <= '0;
            r_marked <= 1'b0;
            r_len_ok <= 1'b0;
            r_len_done <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            if (shift_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.load_byte) begin
                r_len <= r_len + 64'd1;
            end
            if (i_cmd.pad_write) begin
                r_marked <= 1'b1;
                if (r_fill < 6'(LenPos)) r_len_ok <= 1'b1;
                if (r_fill == 6'd63 && r_len_ok) r_len_done <= 1'b1;
            end
            if (i_cmd.start_block) begin
                r_busy <= 1'b1;
                r_rnd <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) r_busy <= 1'b0;
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.reinit) begin
                r_fill <= '0;
                r_len <= '0;
                r_marked <= 1'b0;
                r_len_ok <= 1'b0;
                r_len_done <= 1'b0;
                for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/sha256_msg_load.sv */
// Message loader: picks the byte to shift in, message data or padding.
`default_nettype none
module sha256_msg_load
    import sha256_pkg::*;
(
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_pad,
    input  wire logic        i_marked,
    input  wire logic        i_len_ok,
    input  wire logic [5:0]  i_fill,
    input  wire logic [63:0] i_bits,
    output logic [7:0]       o_byte
);
    always_comb begin
        if (!i_pad) begin
            o_byte = i_byte;
        end else if (!i_marked) begin
            o_byte = PadMark;
        end else if (i_len_ok && i_fill >= 6'(LenPos)) begin
            o_byte = i_bits[{~i_fill[2:0], 3'b000} +: 8];
        end else begin
            o_byte = '0;
        end
    end
endmodule
`default_nettype wire
